>>> rtl/core/periodic_task_slot_scheduler_unit_defines.svh
// Assertion macros used by the scheduler sequencer.
`ifndef PERIODIC_TASK_SLOT_SCHEDULER_UNIT_DEFINES_SVH
`define PERIODIC_TASK_SLOT_SCHEDULER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PTSS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("scheduler assertion failed");
`define PTSS_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("scheduler assertion failed");
`define PTSS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("scheduler assertion failed");
`else
`define PTSS_ASSERT(lbl, prop)
`define PTSS_ASSERT_IMPLY(lbl, ante, cons)
`define PTSS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/ptss_pkg.sv
// Types and constants of the task slot scheduler.
package ptss_pkg;
	localparam logic [1:0] OP_LOAD     = 2'd0;
	localparam logic [1:0] OP_SET_STAT = 2'd1;
	localparam logic [1:0] OP_TICK     = 2'd2;
	localparam logic [1:0] OP_DISPATCH = 2'd3;

	localparam logic [2:0] ST_EMPTY   = 3'd0;
	localparam logic [2:0] ST_READY   = 3'd1;
	localparam logic [2:0] ST_RUN     = 3'd2;
	localparam logic [2:0] ST_FINISH  = 3'd3;
	localparam logic [2:0] ST_STOPPED = 3'd4;

	localparam logic [15:0] NO_LIMIT         = 16'hFFFF;
	localparam logic [15:0] NEVER_CLOSE_IN   = 16'hFFFF;
	localparam logic [31:0] NEVER_CLOSE_TIME = 32'hFFFFFFFF;

	typedef struct packed {
		logic [1:0]  operation;
		logic [3:0]  slot;
		logic [15:0] interval;
		logic [15:0] max_runs;
		logic [15:0] start_offset;
		logic [15:0] end_offset;
		logic [1:0]  new_status;
	} in_item_t;

	typedef struct packed {
		logic [3:0] fired_slot;
		logic       fired;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [31:0] open_time;
		logic [31:0] close_time;
		logic [15:0] period;
		logic [15:0] limit;
		logic [15:0] runs;
	} slot_entry_t;

	typedef struct packed {
		logic load_en;
		logic setst_en;
		logic tick_en;
		logic rd_en;
		logic ev_commit;
		logic mod_start;
		logic mod_commit;
		logic fin_push;
		logic dispatch;
	} ptss_cmd_t;

	typedef struct packed {
		logic ev_hold;
		logic ev_mod;
		logic mod_done;
		logic out_free;
	} ptss_status_t;
endpackage

>>> rtl/core/ptss_divider.sv
// Bit-serial remainder unit: 32-bit dividend by 16-bit divisor.
module ptss_divider import ptss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic        rem_zero
);
	logic [31:0] dvd_q;
	logic [16:0] rem_q;
	logic [15:0] div_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;

	assign trial = {rem_q[15:0], dvd_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			// restore when the trial subtract would go negative
			if (trial >= {1'b0, div_q})
				rem_q <= trial - {1'b0, div_q};
			else
				rem_q <= trial;
		end
	end

	assign done     = done_q;
	assign rem_zero = (rem_q == 17'd0);
endmodule

>>> rtl/core/ptss_datapath.sv
// Slot table, tick counter, evaluation logic and result register.
module ptss_datapath import ptss_pkg::*; #(
	parameter int SLOT_COUNT = 16,
	parameter int IDX_W      = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  in_item_t         item,
	input  ptss_cmd_t        cmd,
	input  logic [IDX_W-1:0] idx,
	output ptss_status_t     sts,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_item
);
	logic [31:0]      tick_q;
	logic [2:0]       st_q [SLOT_COUNT];
	slot_entry_t      mem [SLOT_COUNT];
	slot_entry_t      ent_s1;
	logic [2:0]       sst_s1;
	logic [IDX_W-1:0] load_idx;
	logic             slot_ok;
	slot_entry_t      load_ent;
	slot_entry_t      upd_ent;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	slot_entry_t      mem_wd;
	logic             in_win;
	logic             below;
	logic             elig;
	logic             fire;
	logic             out_free;
	logic             pend_v_q;
	logic [3:0]       pend_slot_q;
	logic             out_v_q;
	out_item_t        out_q;
	logic             div_done;
	logic             rem_zero;

	assign load_idx = IDX_W'(item.slot);
	assign slot_ok  = 32'(item.slot) < 32'(SLOT_COUNT);

	always_comb begin
		load_ent.open_time  = tick_q + 32'(item.start_offset);
		load_ent.close_time = (item.end_offset == NEVER_CLOSE_IN) ? NEVER_CLOSE_TIME
			: tick_q + 32'(item.end_offset);
		load_ent.period     = item.interval;
		load_ent.limit      = item.max_runs;
		load_ent.runs       = '0;
		upd_ent             = ent_s1;
		upd_ent.runs        = ent_s1.runs + 16'd1;
	end

	assign in_win = (tick_q >= ent_s1.open_time) && (tick_q < ent_s1.close_time);
	assign below  = (ent_s1.limit == NO_LIMIT) || (ent_s1.runs < ent_s1.limit);
	assign elig   = ((sst_s1 == ST_READY) || (sst_s1 == ST_FINISH)) && in_win && below;
	assign fire   = cmd.dispatch && (sst_s1 == ST_RUN)
		&& ((ent_s1.period != 16'd0) || (in_win && below));

	assign out_free = !out_v_q || !out_stall;

	assign sts.ev_hold  = fire && pend_v_q && !out_free;
	assign sts.ev_mod   = !cmd.dispatch && elig && (ent_s1.period != 16'd0);
	assign sts.mod_done = div_done;
	assign sts.out_free = out_free;

	assign mem_we = (cmd.load_en && slot_ok) || (cmd.ev_commit && fire);
	assign mem_wa = cmd.load_en ? load_idx : idx;
	assign mem_wd = cmd.load_en ? load_ent : upd_ent;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (cmd.rd_en) begin
			ent_s1 <= mem[idx];
			sst_s1 <= st_q[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			for (int i = 0; i < SLOT_COUNT; i++)
				st_q[i] <= ST_EMPTY;
		end else begin
			if (cmd.tick_en)
				tick_q <= tick_q + 32'd1;
			if (cmd.load_en && slot_ok)
				st_q[load_idx] <= ST_READY;
			if (cmd.setst_en && slot_ok && (st_q[load_idx] != ST_EMPTY))
				st_q[load_idx] <= {1'b0, item.new_status} + 3'd1;
			if (cmd.ev_commit) begin
				if (!cmd.dispatch && elig && (ent_s1.period == 16'd0))
					st_q[idx] <= ST_RUN;
				else if (cmd.dispatch && (sst_s1 == ST_RUN) && (ent_s1.period != 16'd0))
					st_q[idx] <= ST_FINISH;
			end
			if (cmd.mod_commit && rem_zero)
				st_q[idx] <= ST_RUN;
		end
	end

	// Hold one fired slot back so the final one of a pass can carry last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.fin_push)
				pend_v_q <= 1'b0;
			else if (cmd.ev_commit && fire)
				pend_v_q <= 1'b1;
			if ((cmd.ev_commit && fire && pend_v_q) || cmd.fin_push)
				out_v_q <= 1'b1;
			else if (!out_stall)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ev_commit && fire) begin
			pend_slot_q <= 4'(idx);
			if (pend_v_q)
				out_q <= '{fired_slot: pend_slot_q, fired: 1'b1, last: 1'b0};
		end
		if (cmd.fin_push) begin
			if (pend_v_q)
				out_q <= '{fired_slot: pend_slot_q, fired: 1'b1, last: 1'b1};
			else
				out_q <= '{fired_slot: 4'd0, fired: 1'b0, last: 1'b1};
		end
	end

	assign out_valid = out_v_q;
	assign out_item  = out_q;

	ptss_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (tick_q - ent_s1.open_time),
		.divisor  (ent_s1.period),
		.done     (div_done),
		.rem_zero (rem_zero)
	);
endmodule

>>> rtl/core/ptss_ctrl.sv
// Sequencer of the scheduler: takes transactions and walks the slot table.
`include "periodic_task_slot_scheduler_unit_defines.svh"
module ptss_ctrl import ptss_pkg::*; #(
	parameter int SLOT_COUNT = 16,
	parameter int IDX_W      = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       operation,
	output logic             in_stall,
	input  ptss_status_t     sts,
	output ptss_cmd_t        cmd,
	output logic [IDX_W-1:0] idx
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_EV   = 3'd2;
	localparam logic [2:0] S_MOD  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_d;
	logic             disp_q;
	logic             disp_d;
	logic             last_slot;

	assign last_slot = (idx_q == IDX_W'(SLOT_COUNT - 1));
	assign in_stall  = (state_q != S_IDLE);
	assign idx       = idx_q;

	always_comb begin
		cmd          = '0;
		cmd.dispatch = disp_q;
		state_d      = state_q;
		idx_d        = idx_q;
		disp_d       = disp_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (operation)
						OP_LOAD:     cmd.load_en = 1'b1;
						OP_SET_STAT: cmd.setst_en = 1'b1;
						OP_TICK: begin
							cmd.tick_en = 1'b1;
							disp_d      = 1'b0;
							idx_d       = '0;
							state_d     = S_RD;
						end
						OP_DISPATCH: begin
							disp_d  = 1'b1;
							idx_d   = '0;
							state_d = S_RD;
						end
						default: ;
					endcase
				end
			end
			S_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_EV;
			end
			S_EV: begin
				if (sts.ev_mod) begin
					cmd.mod_start = 1'b1;
					state_d       = S_MOD;
				end else if (!sts.ev_hold) begin
					cmd.ev_commit = 1'b1;
					if (last_slot) begin
						state_d = disp_q ? S_FIN : S_IDLE;
					end else begin
						idx_d   = idx_q + IDX_W'(1);
						state_d = S_RD;
					end
				end
			end
			S_MOD: begin
				if (sts.mod_done) begin
					cmd.mod_commit = 1'b1;
					if (last_slot) begin
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_q + IDX_W'(1);
						state_d = S_RD;
					end
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.fin_push = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			disp_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			disp_q  <= disp_d;
		end
	end

	`PTSS_ASSERT_NEXT(a_rd_then_ev, state_q == S_RD, state_q == S_EV)
	`PTSS_ASSERT_NEXT(a_mod_waits, (state_q == S_MOD) && !sts.mod_done, state_q == S_MOD)
	`PTSS_ASSERT_IMPLY(a_fin_room, cmd.fin_push, sts.out_free && disp_q)
	`PTSS_ASSERT(a_one_action, $onehot0({cmd.load_en, cmd.setst_en, cmd.tick_en, cmd.rd_en}))
endmodule

>>> rtl/core/periodic_task_slot_scheduler_unit.sv
// Periodic task slot scheduler top level.
//
// Input channel (in_valid/in_stall/in_item): one transaction per operation:
// load a slot, set a slot's status, advance one tick, or run a dispatch pass.
// Output channel (out_valid/out_stall/out_item): a dispatch pass yields one
// transaction per fired slot in index order, the final one with last set; a
// pass with no firing yields one transaction with fired clear and last set.
// Load and set status yield nothing and do not raise in_stall.
// Tick and dispatch walk the slot table one slot at a time through a single
// table read port, each slot passing through a read and an evaluate state;
// on a tick, a slot whose interval check runs through the bit-serial
// remainder unit also waits in the remainder state until that unit is done.
// After the accepting cycle, in_stall stays high until the walk ends; on a
// dispatch pass it stays high until the final result has been pushed.
// A stalled receiver holds one result in the output register; the walk goes on
// until a further result needs that register while it is still full, then waits.
// Reset clears the tick count, marks every slot empty and empties the output.
module periodic_task_slot_scheduler_unit import ptss_pkg::*; #(
	parameter int SLOT_COUNT = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	ptss_cmd_t        cmd;
	ptss_status_t     sts;
	logic [IDX_W-1:0] idx;

	ptss_ctrl #(
		.SLOT_COUNT (SLOT_COUNT),
		.IDX_W      (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (in_item.operation),
		.in_stall  (in_stall),
		.sts       (sts),
		.cmd       (cmd),
		.idx       (idx)
	);

	ptss_datapath #(
		.SLOT_COUNT (SLOT_COUNT),
		.IDX_W      (IDX_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (in_item),
		.cmd       (cmd),
		.idx       (idx),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);
endmodule
